// ----- rtl/core/ucc_pkg.sv -----
// Shared constants and types for the unique colour table counter.
package ucc_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int COUNT_WIDTH = 24;
   localparam int PIXEL_W     = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
   localparam int STATUS_W    = 2;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [USED_W-1:0]      MAX_UNIQUE_RESET = USED_W'(TABLE_DEPTH);

   localparam logic [STATUS_W-1:0] STATUS_RECORDED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EXCEEDED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   typedef struct packed {
      logic                   srch;
      logic                   done;
      logic                   is_new;
      logic [IDX_W-1:0]       index;
      logic [COUNT_WIDTH-1:0] count;
      logic [PIXEL_W-1:0]     pixel;
   } token_type;

endpackage

// ----- rtl/core/ucc_cell.sv -----
// One table entry: colour and count, with the token stage to the next entry.
module ucc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ucc_pkg::IDX_W-1:0]  cell_index,
   input  logic [ucc_pkg::USED_W-1:0] entries_used,
   input  ucc_pkg::token_type      tok_prev,
   output ucc_pkg::token_type      tok_next
);
   import ucc_pkg::*;

   logic [PIXEL_W-1:0]     colour_ff, colour_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   token_type              tok_ff, tok_in;
   logic                   occupied;
   logic                   first_free;
   logic                   hit;

   always_comb begin
      occupied   = {1'b0, cell_index} < entries_used;
      first_free = {1'b0, cell_index} == entries_used;
      hit        = occupied && (colour_ff == tok_prev.pixel);
      colour_in  = colour_ff;
      count_in   = count_ff;
      tok_in     = tok_prev;
      if (tok_prev.srch) begin
         if (hit) begin
            count_in      = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
            tok_in.srch   = 1'b0;
            tok_in.done   = 1'b1;
            tok_in.is_new = 1'b0;
            tok_in.index  = cell_index;
            tok_in.count  = count_in;
         end else if (first_free) begin
            colour_in     = tok_prev.pixel;
            count_in      = COUNT_WIDTH'(1);
            tok_in.srch   = 1'b0;
            tok_in.done   = 1'b1;
            tok_in.is_new = 1'b1;
            tok_in.index  = cell_index;
            tok_in.count  = COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      colour_ff <= colour_in;
      count_ff  <= count_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_next = tok_ff;

endmodule

// ----- rtl/core/ucc_chain.sv -----
// Row of table cells linked head to tail by the search token.
module ucc_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [ucc_pkg::USED_W-1:0] entries_used,
   input  ucc_pkg::token_type      tok_head,
   output ucc_pkg::token_type      tok_tail
);
   import ucc_pkg::*;

   token_type link [TABLE_DEPTH+1];

   assign link[0] = tok_head;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ucc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (IDX_W'(i)),
         .entries_used (entries_used),
         .tok_prev     (link[i]),
         .tok_next     (link[i+1])
      );
   end

   assign tok_tail = link[TABLE_DEPTH];

endmodule

// ----- rtl/core/unique_colour_table_counter.sv -----
// Top level of the unique colour table counter.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | pixel_argb, image_start, row_start
//   rsp     | out       | rsp_valid/stall    | status, colour_index, is_new,
//           |           |                    | colour_count, colours_found
//   csr     | in        | csr_wr_en          | max_unique
//
// A recorded or dropped pixel walks the cell row one entry per cycle, and no new
// beat is accepted until its result comes back from the tail of the row.
// A pixel ignored after the maximum is exceeded does not enter the cell row.
// Reset is synchronous; table contents are not cleared, but the fill count, control state and tokens are.
// A held result blocks new beats only while rsp_stall holds it.
module unique_colour_table_counter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ucc_pkg::PIXEL_W-1:0]   req_pixel_argb,
   input  logic                          req_image_start,
   input  logic                          req_row_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ucc_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ucc_pkg::IDX_W-1:0]     rsp_colour_index,
   output logic                          rsp_is_new,
   output logic [ucc_pkg::COUNT_WIDTH-1:0] rsp_colour_count,
   output logic [ucc_pkg::USED_W-1:0]    rsp_colours_found,
   input  logic                          csr_wr_en,
   input  logic [ucc_pkg::USED_W-1:0]    csr_wr_data
);
   import ucc_pkg::*;

   state_type              state_ff, state_in;
   logic [USED_W-1:0]      max_unique_ff, max_unique_in;
   logic [USED_W-1:0]      used_ff, used_in;
   logic                   exceeded_ff, exceeded_in;
   token_type              launch_ff, launch_in;
   token_type              tail;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [IDX_W-1:0]       index_ff, index_in;
   logic                   is_new_ff, is_new_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [USED_W-1:0]      found_ff, found_in;
   logic [USED_W-1:0]      used_acc;
   logic                   exc_acc;
   logic                   accept;
   logic                   finish;

   ucc_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .entries_used (used_ff),
      .tok_head     (launch_ff),
      .tok_tail     (tail)
   );

   always_comb begin
      req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
      accept    = req_valid && !req_stall;
      finish    = (state_ff == ST_RUN) && (tail.srch || tail.done);

      used_acc = req_image_start ? '0 : used_ff;
      exc_acc  = req_image_start ? 1'b0 : exceeded_ff;
      if (req_row_start && (used_acc > max_unique_ff)) begin
         exc_acc = 1'b1;
      end

      max_unique_in = csr_wr_en ? csr_wr_data : max_unique_ff;
      state_in      = state_ff;
      used_in       = used_ff;
      exceeded_in   = exceeded_ff;
      launch_in     = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      status_in     = status_ff;
      index_in      = index_ff;
      is_new_in     = is_new_ff;
      count_in      = count_ff;
      found_in      = found_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               used_in     = used_acc;
               exceeded_in = exc_acc;
               if (exc_acc) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STATUS_EXCEEDED;
                  index_in     = '0;
                  is_new_in    = 1'b0;
                  count_in     = '0;
                  found_in     = used_acc;
               end else begin
                  launch_in.srch  = 1'b1;
                  launch_in.pixel = req_pixel_argb;
                  state_in        = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (finish) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (tail.done) begin
                  status_in = STATUS_RECORDED;
                  index_in  = tail.index;
                  is_new_in = tail.is_new;
                  count_in  = tail.count;
                  used_in   = tail.is_new ? used_ff + 1'b1 : used_ff;
                  found_in  = used_in;
               end else begin
                  status_in = STATUS_FULL;
                  index_in  = '0;
                  is_new_in = 1'b0;
                  count_in  = '0;
                  found_in  = used_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      index_ff  <= index_in;
      is_new_ff <= is_new_in;
      count_ff  <= count_in;
      found_ff  <= found_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         max_unique_ff <= MAX_UNIQUE_RESET;
         used_ff       <= '0;
         exceeded_ff   <= 1'b0;
         launch_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_unique_ff <= max_unique_in;
         used_ff       <= used_in;
         exceeded_ff   <= exceeded_in;
         launch_ff     <= launch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_colour_index  = index_ff;
   assign rsp_is_new        = is_new_ff;
   assign rsp_colour_count  = count_ff;
   assign rsp_colours_found = found_ff;

endmodule
